@@ hdl/hcms_pkg.sv @@
// hcms_pkg: shared types and constants of the height color map shade block
// no dependencies; imported by every hcms module and by the top level
package hcms_pkg;

  localparam int unsigned ADDR_W         = 5;   // 8 registers, 4 bytes apart
  localparam int unsigned DATA_W         = 32;
  localparam int unsigned TABLE_SLOTS    = 7;
  localparam int unsigned NUM_W          = 14;  // 50 * 255 fits
  localparam int unsigned QUOT_W         = 6;   // darkening stays in 0..50
  localparam int unsigned BITS_PER_STAGE = 2;
  localparam int unsigned DIV_STAGES     = QUOT_W / BITS_PER_STAGE;
  // input beat to result strobe: lookup, span, divider stages, shade
  localparam int unsigned LATENCY        = 3 + DIV_STAGES;

  localparam logic [7:0]       TOP_LEVEL   = 8'd255;
  localparam logic [NUM_W-1:0] SHADE_DEPTH = NUM_W'(50);
  localparam logic [7:0]       PINK_RED    = 8'd255;
  localparam logic [7:0]       PINK_GREEN  = 8'd109;
  localparam logic [7:0]       PINK_BLUE   = 8'd194;

  typedef enum logic [2:0] {
    REG_ENTRY_COUNT = 3'd0,
    REG_ENTRY_ZERO  = 3'd1,
    REG_ENTRY_ONE   = 3'd2,
    REG_ENTRY_TWO   = 3'd3,
    REG_ENTRY_THREE = 3'd4,
    REG_ENTRY_FOUR  = 3'd5,
    REG_ENTRY_FIVE  = 3'd6,
    REG_ENTRY_SIX   = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  // one beat travelling through the span and divider stages
  typedef struct packed {
    logic              hit;
    rgb_t              color;
    logic [7:0]        span;
    logic [NUM_W-1:0]  rem;
    logic [QUOT_W-1:0] quot;
  } div_beat_t;

endpackage

@@ hdl/hcms_regs.sv @@
// hcms_regs: apb register file holding the entry count and the color table
// depends on hcms_pkg
module hcms_regs import hcms_pkg::*; #(
  parameter int unsigned MAX_ENTRIES = 7
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [ADDR_W-1:0]                 paddr,
  input  logic [DATA_W-1:0]                 pwdata,
  output logic [DATA_W-1:0]                 prdata,
  output logic [2:0]                        entry_count_o,
  output logic [MAX_ENTRIES-1:0][DATA_W-1:0] entries_o
);

  logic [2:0]                         count_q;
  logic [MAX_ENTRIES-1:0][DATA_W-1:0] entry_q;
  logic [2:0]                         reg_idx;
  logic                               wr_en;

  assign reg_idx = paddr[ADDR_W-1:2];
  assign wr_en   = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      entry_q <= '0;
    end else if (wr_en) begin
      if (reg_idx == REG_ENTRY_COUNT) begin
        count_q <= pwdata[2:0];
      end
      // entries past MAX_ENTRIES have no storage, writes there drop
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        if (reg_idx == 3'(i + 1)) begin
          entry_q[i] <= pwdata;
        end
      end
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_idx == REG_ENTRY_COUNT) begin
      prdata = {{(DATA_W-3){1'b0}}, count_q};
    end
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      if (reg_idx == 3'(i + 1)) begin
        prdata = entry_q[i];
      end
    end
  end

  assign entry_count_o = count_q;
  assign entries_o     = entry_q;

endmodule

@@ hdl/hcms_select.sv @@
// hcms_select: table scan stage and span / numerator stage
// depends on hcms_pkg
module hcms_select import hcms_pkg::*; #(
  parameter int unsigned MAX_ENTRIES = 7
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               vld_i,
  input  logic [7:0]                         level_i,
  input  logic [2:0]                         entry_count_i,
  input  logic [MAX_ENTRIES-1:0][DATA_W-1:0] entries_i,
  output logic                               vld_o,
  output div_beat_t                          beat_o
);

  // stage 1 signals
  logic [2:0]                 used;
  logic [MAX_ENTRIES:0][7:0]  h_ext;
  logic                       run;
  logic                       hit_d;
  logic [DATA_W-1:0]          word_d;
  logic [7:0]                 next_d;

  logic                       s1_vld_q;
  logic                       s1_hit_q;
  logic [7:0]                 s1_level_q;
  logic [DATA_W-1:0]          s1_word_q;
  logic [7:0]                 s1_next_q;

  // stage 2 signals
  logic [7:0]                 base_h;
  logic [7:0]                 span;
  logic [7:0]                 offset;
  logic                       shade_en;
  div_beat_t                  beat_d;

  logic                       s2_vld_q;
  div_beat_t                  s2_beat_q;

  assign used = (entry_count_i > 3'(MAX_ENTRIES)) ? 3'(MAX_ENTRIES) : entry_count_i;

  always_comb begin
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      h_ext[i] = entries_i[i][31:24];
    end
    h_ext[MAX_ENTRIES] = TOP_LEVEL;
  end

  // entries take over while they sit at or below the level
  always_comb begin
    run    = 1'b1;
    hit_d  = 1'b0;
    word_d = '0;
    next_d = TOP_LEVEL;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      run = run & (4'(i) < {1'b0, used}) & (level_i >= h_ext[i]);
      if (run) begin
        hit_d  = 1'b1;
        word_d = entries_i[i];
        next_d = (4'(i + 1) < {1'b0, used}) ? h_ext[i+1] : TOP_LEVEL;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (vld_i) begin
      s1_hit_q   <= hit_d;
      s1_level_q <= level_i;
      s1_word_q  <= word_d;
      s1_next_q  <= next_d;
    end
  end

  // zero or negative span, or a level past the span, gives no darkening
  always_comb begin
    base_h   = s1_word_q[31:24];
    span     = s1_next_q - base_h;
    offset   = s1_level_q - base_h;
    shade_en = (s1_next_q > base_h) && (offset <= span);
    beat_d.hit         = s1_hit_q;
    beat_d.color.red   = s1_word_q[23:16];
    beat_d.color.green = s1_word_q[15:8];
    beat_d.color.blue  = s1_word_q[7:0];
    beat_d.span        = shade_en ? span : 8'd1;
    beat_d.rem         = shade_en ? (NUM_W'(span - offset) * SHADE_DEPTH) : '0;
    beat_d.quot        = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else begin
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_vld_q) begin
      s2_beat_q <= beat_d;
    end
  end

  assign vld_o  = s2_vld_q;
  assign beat_o = s2_beat_q;

endmodule

@@ hdl/hcms_div.sv @@
// hcms_div: pipelined restoring divider, two quotient bits per stage
// depends on hcms_pkg
module hcms_div import hcms_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      vld_i,
  input  div_beat_t beat_i,
  output logic      vld_o,
  output div_beat_t beat_o
);

  logic      vld_q  [DIV_STAGES+1];
  div_beat_t beat_q [DIV_STAGES+1];

  assign vld_q[0]  = vld_i;
  assign beat_q[0] = beat_i;

  for (genvar st = 0; st < DIV_STAGES; st++) begin : g_stage
    div_beat_t        beat_d;
    logic [NUM_W-1:0] trial;

    always_comb begin
      beat_d = beat_q[st];
      trial  = '0;
      for (int j = 0; j < BITS_PER_STAGE; j++) begin
        trial = NUM_W'(beat_d.span) << (QUOT_W - 1 - st * BITS_PER_STAGE - j);
        if (beat_d.rem >= trial) begin
          beat_d.rem = beat_d.rem - trial;
          beat_d.quot[QUOT_W - 1 - st * BITS_PER_STAGE - j] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[st+1] <= 1'b0;
      end else begin
        vld_q[st+1] <= vld_q[st];
      end
    end

    always_ff @(posedge clk_i) begin
      if (vld_q[st]) begin
        beat_q[st+1] <= beat_d;
      end
    end
  end

  assign vld_o  = vld_q[DIV_STAGES];
  assign beat_o = beat_q[DIV_STAGES];

endmodule

@@ hdl/height_color_map_shade.sv @@
// results: a beat accepted at one clock edge passes the lookup, span, divider and shade
//   registers, then shows on the result ports for exactly one cycle, marked by result_valid_o
// throughput: one beat per cycle; busy never rises, the pipeline never stalls
// the latency is set by the six register stages, the divider taking three of them
// reset: rst_ni clears the configuration registers and the valid flags to zero and drops every in-flight beat
// height_color_map_shade: top level, depends on hcms_pkg, hcms_regs,
//   hcms_select and hcms_div
module height_color_map_shade import hcms_pkg::*; #(
  parameter int unsigned MAX_ENTRIES = 7
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // command channel
  input  logic              start,
  output logic              busy,
  input  logic [7:0]        height_level_i,
  // results, one cycle each
  output logic              result_valid_o,
  output logic [7:0]        red_o,
  output logic [7:0]        green_o,
  output logic [7:0]        blue_o,
  output logic              table_hit_o,
  // apb configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  logic [2:0]                         entry_count;
  logic [MAX_ENTRIES-1:0][DATA_W-1:0] entries;
  logic                               in_beat;

  logic                               sel_vld;
  div_beat_t                          sel_beat;
  logic                               div_vld;
  div_beat_t                          div_beat;

  logic [7:0]                         dark;
  rgb_t                               shade_d;

  logic                               out_vld_q;
  rgb_t                               out_color_q;
  logic                               out_hit_q;

  // every stage advances each cycle, so a new beat is always welcome
  assign busy    = 1'b0;
  assign pready  = 1'b1;
  assign in_beat = start & ~busy;

  // configuration registers; the user must write them only while the pipeline is empty, the block does not enforce it
  hcms_regs #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_regs (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .entry_count_o (entry_count),
    .entries_o     (entries)
  );

  // stages 1 and 2: parallel compare against all entries, then span and
  // the numerator 50 * (span - offset)
  hcms_select #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_select (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .vld_i         (in_beat),
    .level_i       (height_level_i),
    .entry_count_i (entry_count),
    .entries_i     (entries),
    .vld_o         (sel_vld),
    .beat_o        (sel_beat)
  );

  // stages 3 to 5: numerator / span, quotient lands in 0..50
  hcms_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (sel_vld),
    .beat_i (sel_beat),
    .vld_o  (div_vld),
    .beat_o (div_beat)
  );

  // stage 6: darken each channel with saturation at zero, pink on a miss
  always_comb begin
    dark = 8'(div_beat.quot);
    if (div_beat.hit) begin
      shade_d.red   = (div_beat.color.red   > dark) ? div_beat.color.red   - dark : '0;
      shade_d.green = (div_beat.color.green > dark) ? div_beat.color.green - dark : '0;
      shade_d.blue  = (div_beat.color.blue  > dark) ? div_beat.color.blue  - dark : '0;
    end else begin
      shade_d.red   = PINK_RED;
      shade_d.green = PINK_GREEN;
      shade_d.blue  = PINK_BLUE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= div_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (div_vld) begin
      out_color_q <= shade_d;
      out_hit_q   <= div_beat.hit;
    end
  end

  assign result_valid_o = out_vld_q;
  assign red_o          = out_color_q.red;
  assign green_o        = out_color_q.green;
  assign blue_o         = out_color_q.blue;
  assign table_hit_o    = out_hit_q;

endmodule

@@ hdl/hcms_checker.sv @@
// hcms_checker: port-level checks of the shade pipeline, bound to the top level
// depends on hcms_pkg and height_color_map_shade
module hcms_checker import hcms_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start,
  input logic       busy,
  input logic       result_valid_o,
  input logic [7:0] red_o,
  input logic [7:0] green_o,
  input logic [7:0] blue_o,
  input logic       table_hit_o
);

  // every accepted beat yields a result
  a_beat_to_result: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##LATENCY result_valid_o
  ) else $error("accepted beat produced no result");

  // no result without a matching accepted beat before it
  a_result_from_beat: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(start && !busy, LATENCY)
  ) else $error("result without matching beat");

  // a miss always gives the pink fallback
  a_miss_is_pink: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !table_hit_o) |->
      (red_o == PINK_RED && green_o == PINK_GREEN && blue_o == PINK_BLUE)
  ) else $error("miss result is not pink");

endmodule

bind height_color_map_shade hcms_checker u_hcms_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .result_valid_o (result_valid_o),
  .red_o          (red_o),
  .green_o        (green_o),
  .blue_o         (blue_o),
  .table_hit_o    (table_hit_o)
);

@@ tb/height_color_map_shade_tb.sv @@
// height_color_map_shade_tb: self-checking bench for the height to color shading block
// drives pixels on the start/busy channel and the table over apb, checks every result
// depends on hcms_pkg and height_color_map_shade, nothing else
module height_color_map_shade_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import hcms_pkg::*;

  localparam int unsigned MAX_ENTRIES      = 7;
  localparam int unsigned CLK_PERIOD       = 10;
  // longest legal quiet stretch is a config reload plus a drain, well under this
  localparam int unsigned STALL_LIMIT      = 2000;
  localparam int unsigned RANDOM_PHASES    = 12;
  localparam int unsigned LEVELS_PER_PHASE = 75;

  typedef logic [7:0] level_q_t[$];

  // one result beat: shaded color plus the table hit flag
  typedef struct packed {
    rgb_t color;
    logic hit;
  } pixel_t;

  // scoreboard: own copy of the table, predicts the shaded pixel per accepted level
  class shade_board;
    logic [2:0]  count_reg;
    logic [31:0] table_word [TABLE_SLOTS];
    pixel_t      shade_q[$];
    int          errors;

    function new();
      count_reg = '0;
      foreach (table_word[i]) table_word[i] = '0;
      errors = 0;
    endfunction

    function void write_reg(reg_idx_e idx, logic [31:0] value);
      if (idx == REG_ENTRY_COUNT) begin
        count_reg = value[2:0];
      end else begin
        table_word[int'(idx) - int'(REG_ENTRY_ZERO)] = value;
      end
    endfunction

    function logic [7:0] darken(logic [7:0] c, int unsigned d);
      return (c > d) ? 8'(int'(c) - int'(d)) : 8'd0;
    endfunction

    function pixel_t shade_lookup(logic [7:0] lvl);
      int unsigned used, chosen, h, nxt, span, offset, dark;
      logic        hit;
      logic [31:0] word;
      pixel_t      px;
      used = count_reg;
      if (used > MAX_ENTRIES) used = MAX_ENTRIES;
      hit = 1'b0;
      chosen = 0;
      // the scan stops at the first entry above the level
      for (int unsigned i = 0; i < used; i++) begin
        if (lvl >= table_word[i][31:24]) begin
          hit = 1'b1;
          chosen = i;
        end else begin
          break;
        end
      end
      px.color.red = PINK_RED;
      px.color.green = PINK_GREEN;
      px.color.blue = PINK_BLUE;
      px.hit = hit;
      if (hit) begin
        word = table_word[chosen];
        h = word[31:24];
        nxt = TOP_LEVEL;
        if (chosen + 1 < used) nxt = table_word[chosen + 1][31:24];
        offset = lvl - h;
        dark = 0;
        // zero or negative span leaves the color as is
        if (nxt > h) begin
          span = nxt - h;
          if (offset <= span) dark = SHADE_DEPTH * (span - offset) / span;
        end
        px.color.red = darken(word[23:16], dark);
        px.color.green = darken(word[15:8], dark);
        px.color.blue = darken(word[7:0], dark);
      end
      return px;
    endfunction

    function void note_level(logic [7:0] lvl);
      shade_q.push_back(shade_lookup(lvl));
    endfunction

    function void report(string field, int unsigned want, int unsigned got);
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      errors++;
    endfunction

    function void check_pixel(pixel_t got);
      pixel_t want;
      if (shade_q.size() == 0) begin
        $display("%0t: unexpected result r %0d g %0d b %0d hit %0d", $time,
                 got.color.red, got.color.green, got.color.blue, got.hit);
        errors++;
        return;
      end
      want = shade_q.pop_front();
      if (got.color.red !== want.color.red) report("red", want.color.red, got.color.red);
      if (got.color.green !== want.color.green)
        report("green", want.color.green, got.color.green);
      if (got.color.blue !== want.color.blue) report("blue", want.color.blue, got.color.blue);
      if (got.hit !== want.hit) report("table_hit", want.hit, got.hit);
    endfunction

    function int pending();
      return shade_q.size();
    endfunction
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              start;
  logic              busy;
  logic [7:0]        height_level_i;
  logic              result_valid_o;
  logic [7:0]        red_o;
  logic [7:0]        green_o;
  logic [7:0]        blue_o;
  logic              table_hit_o;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  shade_board  board = new();
  int unsigned stall_cycles = 0;
  // set during the stretch where the sender never pauses
  bit          steady = 1'b0;

  height_color_map_shade #(
    .MAX_ENTRIES(MAX_ENTRIES)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .height_level_i(height_level_i),
    .result_valid_o(result_valid_o),
    .red_o         (red_o),
    .green_o       (green_o),
    .blue_o        (blue_o),
    .table_hit_o   (table_hit_o),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  // monitor: sample at the edge, before the design's own updates land
  // note before check so a same-edge beat and result stay in order
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      stall_cycles <= 0;
    end else begin
      if (start && !busy) board.note_level(height_level_i);
      if (result_valid_o) board.check_pixel(pixel_t'({red_o, green_o, blue_o, table_hit_o}));
      // watchdog: any accepted beat, result or register write counts as progress
      if ((start && !busy) || result_valid_o || (psel && penable && pwrite && pready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("status: fail");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  // apb write: setup cycle, then access until pready; model updated when it lands
  task automatic reg_write(reg_idx_e idx, logic [31:0] value);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_W'({idx, 2'b00});
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    board.write_reg(idx, value);
  endtask

  // every register gets written on each reload
  task automatic load_table(logic [31:0] count_word, logic [31:0] words [TABLE_SLOTS]);
    reg_write(REG_ENTRY_COUNT, count_word);
    for (int i = 0; i < TABLE_SLOTS; i++) begin
      reg_write(reg_idx_e'(int'(REG_ENTRY_ZERO) + i), words[i]);
    end
  endtask

  // occasional one-cycle sender gap, with noise on the data while start is low
  task automatic maybe_pause();
    if (!steady && $urandom_range(0, 99) < 6) begin
      start <= 1'b0;
      height_level_i <= 8'($urandom);
      @(posedge clk_i);
    end
  endtask

  // hold start high until the beat is taken; start stays up for back to back beats
  task automatic send_level(logic [7:0] lvl);
    maybe_pause();
    start <= 1'b1;
    height_level_i <= lvl;
    do @(posedge clk_i); while (busy);
  endtask

  task automatic send_levels(level_q_t lvls);
    foreach (lvls[i]) send_level(lvls[i]);
  endtask

  // let the pipeline empty before touching the table
  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (board.pending() != 0) @(posedge clk_i);
    repeat (LATENCY + 2) @(posedge clk_i);
  endtask

  initial begin
    logic [31:0] words [TABLE_SLOTS];
    int unsigned heights[$];
    int unsigned cnt, mode;
    int          v;
    logic [7:0]  lvl;

    rst_ni <= 1'b0;
    start <= 1'b0;
    height_level_i <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty table after reset: pink everywhere
    send_levels('{8'h00, 8'h80, 8'hFF});
    drain();

    // sorted full table, last entry at the top level; thresholds and their neighbors,
    // black and white colors, partial saturation, zero span at level 255
    words = '{32'h10FF0080, 32'h30000000, 32'h50FFFFFF, 32'h801E3228,
              32'hA0123456, 32'hD0C8640A, 32'hFFABCDEF};
    load_table(32'd7, words);
    send_levels('{8'h00, 8'h0F, 8'h10, 8'h2F, 8'h30, 8'h50, 8'h7F, 8'h80,
                  8'hA0, 8'hCF, 8'hD0, 8'hFE, 8'hFF});
    drain();

    // unsorted table, three entries in use, count written with junk upper bits
    words = '{32'h80408000, 32'h20FF1000, 32'hC0050607, 32'h40FFFFFF,
              32'h00000000, 32'hFFFFFFFF, 32'h10101010};
    load_table(32'hFFFFFFFB, words);
    send_levels('{8'h10, 8'h80, 8'h90, 8'hC0, 8'hFF});
    drain();

    // all ones table: unused with count zero, then all entries at the top level
    words = '{default: 32'hFFFFFFFF};
    load_table(32'hFFFFFFF8, words);
    send_levels('{8'h00, 8'hFF});
    drain();
    load_table(32'd7, words);
    send_levels('{8'hFE, 8'hFF});
    drain();

    // all zero table: every level hits the last entry, channels clamp at zero
    words = '{default: 32'h00000000};
    load_table(32'd7, words);
    send_levels('{8'h00, 8'h80, 8'hFF});
    drain();

    // random phases: mostly sorted tables, some with duplicate heights, some unsorted
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      steady = (p == 5 || p == 6);
      mode = $urandom_range(0, 9);
      if (p == 0) cnt = 7;
      else if (p == 1) cnt = 1;
      else if (p == 2) cnt = 0;
      else cnt = $urandom_range(0, 7);
      heights.delete();
      for (int i = 0; i < TABLE_SLOTS; i++) begin
        if (mode >= 6 && mode <= 7) begin
          v = $urandom_range(0, 4) * 64;
          heights.push_back((v > 255) ? 255 : v);
        end else begin
          heights.push_back($urandom_range(0, 255));
        end
      end
      if (mode < 8) heights.sort();
      foreach (words[i]) words[i] = {8'(heights[i]), 24'($urandom)};
      load_table({29'($urandom), 3'(cnt)}, words);
      for (int n = 0; n < LEVELS_PER_PHASE; n++) begin
        // a share of levels lands right on or next to a threshold in use
        if (cnt > 0 && $urandom_range(0, 9) < 3) begin
          v = int'(heights[$urandom_range(0, cnt - 1)]) + int'($urandom_range(0, 2)) - 1;
          if (v < 0) v = 0;
          if (v > 255) v = 255;
          lvl = 8'(v);
        end else begin
          lvl = 8'($urandom);
        end
        send_level(lvl);
      end
      drain();
    end

    if (board.errors == 0 && board.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/hcms_pkg.sv
hdl/hcms_regs.sv
hdl/hcms_select.sv
hdl/hcms_div.sv
hdl/height_color_map_shade.sv
hdl/hcms_checker.sv
tb/height_color_map_shade_tb.sv
